// ----- design/gate_weight_map_core_assert.svh -----
// Assertion macros used by the gate weight map checker
`ifndef GATE_WEIGHT_MAP_CORE_ASSERT_SVH
`define GATE_WEIGHT_MAP_CORE_ASSERT_SVH

// check at every clock edge outside of reset
`define GWM_ASSERT(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) expr) else $error(msg);

// check at every clock edge, reset included
`define GWM_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) expr) else $error(msg);

`endif

// ----- design/gwm_pkg.sv -----
// Types and constants of the gate weight map
package gwm_pkg;

    localparam int unsigned WIDTH = 16;
    localparam logic signed [WIDTH-1:0] ONE_Q12 = 16'sd4096;

    localparam logic [2:0] REG_REF_LEVEL   = 3'd0;
    localparam logic [2:0] REG_SLOPE       = 3'd1;
    localparam logic [2:0] REG_RAMP        = 3'd2;
    localparam logic [2:0] REG_FLOOR_LEVEL = 3'd3;
    localparam logic [2:0] REG_CAP_LEVEL   = 3'd4;
    localparam logic [2:0] REG_USE_MIN     = 3'd5;

    typedef logic signed [WIDTH-1:0] t_q12;

    typedef struct packed {
        t_q12 ref_level;
        t_q12 slope;
        t_q12 ramp;
        t_q12 floor_level;
        t_q12 cap_level;
        logic use_min;
    } t_cfg;

    typedef enum logic [1:0] {
        PH_FIRST = 2'd0,
        PH_ONE   = 2'd1,
        PH_MANY  = 2'd2
    } t_phase;

endpackage

// ----- design/gate_weight_map_core.sv -----
// Top level: per-column gate weight mapping of a sample row
// An accepted item's results pass the pipeline register, then the result buffer.
// Throughput: one item per cycle while o_stall is low; output runs at one result
// per cycle while i_stall is low, so a row's last item (two results) is absorbed
// by a 4-entry result buffer before the input stalls.
// Reset: synchronous active low; clears row state, buffer and registers to defaults.
module gate_weight_map_core
    import gwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_q12        i_gate_sample,
    input  logic        i_last_in_row,
    output logic        o_valid,
    input  logic        i_stall,
    output t_q12        o_weight,
    output logic        o_end_of_row
);

    t_cfg   r_cfg;
    t_phase r_phase, n_phase;
    t_q12   r_prev, r_prev2;

    logic   r_p_valid, r_p_two;
    t_q12   r_p_sel0, r_p_sel1;

    t_q12       r_buf_w [4];
    logic [3:0] r_buf_e;
    logic [1:0] r_rd, r_wr;
    logic [2:0] r_cnt;

    logic   cfg_wr, in_acc, pop, p_adv;
    logic   s_emit, s_two;
    t_q12   s_sel0, s_min;
    t_q12   w0, w1;
    logic [2:0] need, space;
    logic [1:0] wr1;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_level   <= '0;
            r_cfg.slope       <= ONE_Q12;
            r_cfg.ramp        <= '0;
            r_cfg.floor_level <= '0;
            r_cfg.cap_level   <= ONE_Q12;
            r_cfg.use_min     <= 1'b1;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_REF_LEVEL:   r_cfg.ref_level   <= pwdata[15:0];
                REG_SLOPE:       r_cfg.slope       <= pwdata[15:0];
                REG_RAMP:        r_cfg.ramp        <= pwdata[15:0];
                REG_FLOOR_LEVEL: r_cfg.floor_level <= pwdata[15:0];
                REG_CAP_LEVEL:   r_cfg.cap_level   <= pwdata[15:0];
                REG_USE_MIN:     r_cfg.use_min     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_REF_LEVEL:   prdata = {16'd0, r_cfg.ref_level};
            REG_SLOPE:       prdata = {16'd0, r_cfg.slope};
            REG_RAMP:        prdata = {16'd0, r_cfg.ramp};
            REG_FLOOR_LEVEL: prdata = {16'd0, r_cfg.floor_level};
            REG_CAP_LEVEL:   prdata = {16'd0, r_cfg.cap_level};
            REG_USE_MIN:     prdata = {31'd0, r_cfg.use_min};
            default:         prdata = '0;
        endcase
    end

    // result buffer flow control
    assign pop   = (r_cnt != 3'd0) && !i_stall;
    assign need  = r_p_two ? 3'd2 : 3'd1;
    assign space = 3'd4 - r_cnt + {2'd0, pop};
    assign p_adv = r_p_valid && (need <= space);
    assign o_stall = r_p_valid && !p_adv;
    assign in_acc  = i_valid && !o_stall;

    always_comb begin
        s_min = r_prev2;
        if (r_prev < s_min) begin
            s_min = r_prev;
        end
        if (i_gate_sample < s_min) begin
            s_min = i_gate_sample;
        end
    end

    always_comb begin
        if (i_last_in_row) begin
            n_phase = PH_FIRST;
        end else begin
            unique case (r_phase)
                PH_FIRST: n_phase = PH_ONE;
                default:  n_phase = PH_MANY;
            endcase
        end
    end

    always_comb begin
        unique case (r_phase)
            PH_FIRST: begin
                s_emit = i_last_in_row;
                s_sel0 = i_gate_sample;
            end
            PH_ONE: begin
                s_emit = 1'b1;
                s_sel0 = r_prev;
            end
            default: begin
                s_emit = 1'b1;
                s_sel0 = r_cfg.use_min ? s_min : r_prev;
            end
        endcase
        s_two = i_last_in_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_FIRST;
            r_prev  <= '0;
            r_prev2 <= '0;
        end else if (in_acc) begin
            r_phase <= n_phase;
            r_prev  <= i_last_in_row ? '0 : i_gate_sample;
            r_prev2 <= i_last_in_row ? '0 : r_prev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (in_acc && s_emit) begin
            r_p_valid <= 1'b1;
        end else if (p_adv) begin
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s_emit) begin
            r_p_two  <= s_two;
            r_p_sel0 <= s_sel0;
            r_p_sel1 <= i_gate_sample;
        end
    end

    gwm_map u_map0 (
        .i_cfg    (r_cfg),
        .i_gate   (r_p_sel0),
        .o_weight (w0)
    );

    gwm_map u_map1 (
        .i_cfg    (r_cfg),
        .i_gate   (r_p_sel1),
        .o_weight (w1)
    );

    assign wr1 = r_wr + 2'd1;

    always_ff @(posedge i_clk) begin
        if (p_adv) begin
            r_buf_w[r_wr] <= w0;
            if (r_p_two) begin
                r_buf_w[wr1] <= w1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf_e <= '0;
            r_rd    <= '0;
            r_wr    <= '0;
            r_cnt   <= '0;
        end else begin
            if (p_adv) begin
                r_buf_e[r_wr] <= 1'b0;
                if (r_p_two) begin
                    r_buf_e[wr1] <= 1'b1;
                end
                r_wr <= r_wr + need[1:0];
            end
            if (pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + (p_adv ? need : 3'd0) - {2'd0, pop};
        end
    end

    assign o_valid      = (r_cnt != 3'd0);
    assign o_weight     = r_buf_w[r_rd];
    assign o_end_of_row = r_buf_e[r_rd];

endmodule

// ----- design/gwm_map.sv -----
// Gain, offset and clamp of one gate value into a weight
module gwm_map
    import gwm_pkg::*;
(
    input  t_cfg i_cfg,
    input  t_q12 i_gate,
    output t_q12 o_weight
);

    logic signed [16:0] diff;
    logic signed [32:0] diff_x;
    logic signed [32:0] slope_x;
    logic signed [32:0] prod;
    logic signed [20:0] quot;
    logic signed [21:0] sum;

    assign diff    = 17'(i_cfg.ref_level) - 17'(i_gate);
    assign diff_x  = 33'(diff);
    assign slope_x = 33'(i_cfg.slope);
    assign prod    = diff_x * slope_x;
    assign quot    = prod[32:12];
    assign sum     = 22'(quot) + 22'(i_cfg.ramp);

    always_comb begin
        priority if (sum > 22'(i_cfg.cap_level)) begin
            o_weight = ONE_Q12;
        end else if (sum < 22'(i_cfg.floor_level)) begin
            o_weight = i_cfg.floor_level;
        end else begin
            o_weight = sum[15:0];
        end
    end

endmodule

// ----- design/gwm_checker.sv -----
// Port-level checks of the gate weight map and their binding
`include "gate_weight_map_core_assert.svh"

module gwm_checker
    import gwm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input t_q12        o_weight,
    input logic        o_end_of_row
);

    logic r_last_eor;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_eor <= 1'b0;
        end else if (o_valid && !i_stall) begin
            r_last_eor <= o_end_of_row;
        end
    end

    `GWM_ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !o_valid && !o_stall,
        "not empty after reset")
    `GWM_ASSERT(a_out_hold,
        o_valid && i_stall |=> o_valid && $stable(o_weight) && $stable(o_end_of_row),
        "stalled result changed")
    `GWM_ASSERT(a_row_two, o_valid && !i_stall && o_end_of_row |-> !r_last_eor,
        "row end without preceding column")

endmodule

bind gate_weight_map_core gwm_checker u_gwm_checker (.*);

// ----- tb/sv/gate_weight_monitor.sv -----
// Weight monitor: tracks the register port and both channels, predicts and checks each weight
module gate_weight_monitor
    import gwm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [4:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    input  logic        i_item_valid,
    input  logic        i_item_stall,
    input  t_q12        i_gate_sample,
    input  logic        i_last_in_row,
    input  logic        i_res_valid,
    input  logic        i_res_stall,
    input  t_q12        i_weight,
    input  logic        i_end_of_row,
    output int          o_pending,
    output int          o_fail_count,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_q12 weight;
        logic end_of_row;
    } t_weight_item;

    t_weight_item weight_q[$];
    t_cfg         cfg;
    t_q12         prev_g;
    t_q12         prev_prev_g;
    t_phase       phase;
    int           fails = 0;
    int           checked = 0;

    function automatic t_q12 map_gate(t_q12 g);
        logic signed [16:0] diff;
        logic signed [32:0] prod;
        logic signed [22:0] level;
        diff  = cfg.ref_level - g;
        prod  = diff * cfg.slope;
        level = (prod >>> 12) + cfg.ramp;
        if (level > cfg.cap_level) return ONE_Q12;
        if (level < cfg.floor_level) return cfg.floor_level;
        return t_q12'(level);
    endfunction

    function automatic t_q12 min_of3(t_q12 a, t_q12 b, t_q12 c);
        t_q12 m;
        m = a;
        if (b < m) m = b;
        if (c < m) m = c;
        return m;
    endfunction

    function automatic void predict_item(t_q12 g, logic last);
        t_q12 pick;
        if (phase == PH_FIRST) begin
            if (last) begin
                weight_q.push_back(t_weight_item'{map_gate(g), 1'b0});
                weight_q.push_back(t_weight_item'{map_gate(g), 1'b1});
            end
        end else begin
            pick = (phase == PH_MANY && cfg.use_min) ? min_of3(prev_prev_g, prev_g, g) : prev_g;
            weight_q.push_back(t_weight_item'{map_gate(pick), 1'b0});
            if (last) weight_q.push_back(t_weight_item'{map_gate(g), 1'b1});
        end
        if (last) begin
            phase       = PH_FIRST;
            prev_g      = '0;
            prev_prev_g = '0;
        end else begin
            prev_prev_g = prev_g;
            prev_g      = g;
            phase       = (phase == PH_FIRST) ? PH_ONE : PH_MANY;
        end
    endfunction

    function automatic void check_weight(t_q12 w, logic eor);
        t_weight_item want;
        if (weight_q.size() == 0) begin
            fails++;
            $display("%0t: unexpected weight %0d end_of_row %0b", $time, w, eor);
            return;
        end
        want = weight_q.pop_front();
        checked++;
        if (w !== want.weight) begin
            fails++;
            $display("%0t: weight expected %0d, got %0d", $time, want.weight, w);
        end
        if (eor !== want.end_of_row) begin
            fails++;
            $display("%0t: end_of_row expected %0b, got %0b", $time, want.end_of_row, eor);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.ref_level   = '0;
            cfg.slope       = ONE_Q12;
            cfg.ramp        = '0;
            cfg.floor_level = '0;
            cfg.cap_level   = ONE_Q12;
            cfg.use_min     = 1'b1;
            prev_g          = '0;
            prev_prev_g     = '0;
            phase           = PH_FIRST;
            weight_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_REF_LEVEL:   cfg.ref_level   = i_pwdata[15:0];
                    REG_SLOPE:       cfg.slope       = i_pwdata[15:0];
                    REG_RAMP:        cfg.ramp        = i_pwdata[15:0];
                    REG_FLOOR_LEVEL: cfg.floor_level = i_pwdata[15:0];
                    REG_CAP_LEVEL:   cfg.cap_level   = i_pwdata[15:0];
                    REG_USE_MIN:     cfg.use_min     = i_pwdata[0];
                    default: ;
                endcase
            end
            if (i_res_valid && !i_res_stall) check_weight(i_weight, i_end_of_row);
            if (i_item_valid && !i_item_stall) predict_item(i_gate_sample, i_last_in_row);
        end
        o_pending    <= weight_q.size();
        o_fail_count <= fails;
        o_checked    <= checked;
    end

endmodule

// ----- tb/sv/tb_gate_weight_map_core.sv -----
// Testbench top: drives sample rows and register writes into the gate weight map, gives the verdict
module tb_gate_weight_map_core
    import gwm_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] REG_UNUSED_A = 3'd6;
    localparam logic [2:0] REG_UNUSED_B = 3'd7;
    localparam t_q12       Q_MAX        = 16'sh7FFF;
    localparam t_q12       Q_MIN        = 16'sh8000;
    localparam int         SETTLE       = 8;
    localparam int         QUIET_LIMIT  = 2000;
    localparam int         ROW_ITEMS    = 860;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid;
    logic        o_stall;
    t_q12        i_gate_sample;
    logic        i_last_in_row;
    logic        o_valid;
    logic        i_stall;
    t_q12        o_weight;
    logic        o_end_of_row;

    int   pending_weights;
    int   fail_count;
    int   weights_checked;
    int   quiet = 0;
    int   items_sent = 0;
    int   rows_sent = 0;
    int   reg_writes = 0;
    int   configs_loaded = 0;
    bit   tx_calm = 1'b0;
    bit   rx_calm = 1'b0;
    t_cfg cur;

    gate_weight_map_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_gate_sample (i_gate_sample),
        .i_last_in_row (i_last_in_row),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_weight      (o_weight),
        .o_end_of_row  (o_end_of_row)
    );

    gate_weight_monitor u_weight_monitor (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_pready      (pready),
        .i_item_valid  (i_valid),
        .i_item_stall  (o_stall),
        .i_gate_sample (i_gate_sample),
        .i_last_in_row (i_last_in_row),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_weight      (o_weight),
        .i_end_of_row  (o_end_of_row),
        .o_pending     (pending_weights),
        .o_fail_count  (fail_count),
        .o_checked     (weights_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic int row_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 1;
        if (r < 50) return $urandom_range(2, 4);
        if (r < 92) return $urandom_range(5, 12);
        return $urandom_range(20, 48);
    endfunction

    function automatic t_q12 pick_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2) return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
        if (r < 5) return t_q12'($urandom);
        return t_q12'(int'(cur.ref_level) + int'($urandom_range(0, 4096)) - 2048);
    endfunction

    function automatic t_cfg random_cfg();
        t_cfg c;
        if ($urandom_range(0, 2) == 0) begin
            c.ref_level   = t_q12'($urandom);
            c.slope       = t_q12'($urandom);
            c.ramp        = t_q12'($urandom);
            c.floor_level = t_q12'($urandom);
            c.cap_level   = t_q12'($urandom);
        end else begin
            c.ref_level   = t_q12'(int'($urandom_range(0, 12288)) - 4096);
            c.slope       = t_q12'(int'($urandom_range(0, 16384)) - 8192);
            c.ramp        = t_q12'(int'($urandom_range(0, 8192)) - 4096);
            c.floor_level = t_q12'(int'($urandom_range(0, 2048)) - 1024);
            c.cap_level   = t_q12'($urandom_range(2048, 8192));
        end
        c.use_min = 1'($urandom_range(0, 1));
        return c;
    endfunction

    function automatic t_cfg corner_cfg(int k);
        t_cfg c;
        case (k)
            0: c = '{ref_level: Q_MAX, slope: Q_MAX, ramp: Q_MAX,
                     floor_level: Q_MIN, cap_level: Q_MAX, use_min: 1'b1};
            1: c = '{ref_level: Q_MIN, slope: Q_MAX, ramp: Q_MIN,
                     floor_level: Q_MIN, cap_level: Q_MIN, use_min: 1'b0};
            2: c = '{ref_level: '0, slope: Q_MIN, ramp: '0,
                     floor_level: Q_MAX, cap_level: Q_MAX, use_min: 1'b1};
            default: c = '{ref_level: Q_MAX, slope: Q_MIN, ramp: Q_MIN,
                           floor_level: Q_MIN, cap_level: Q_MIN, use_min: 1'b0};
        endcase
        return c;
    endfunction

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        reg_writes++;
        @(posedge i_clk);
    endtask

    task automatic load_config(input t_cfg c);
        reg_write(REG_REF_LEVEL, 32'(c.ref_level));
        reg_write(REG_SLOPE, 32'(c.slope));
        reg_write(REG_RAMP, 32'(c.ramp));
        reg_write(REG_FLOOR_LEVEL, 32'(c.floor_level));
        reg_write(REG_CAP_LEVEL, 32'(c.cap_level));
        reg_write(REG_USE_MIN, 32'(c.use_min));
        cur = c;
        configs_loaded++;
    endtask

    task automatic send_item(input t_q12 g, input logic last);
        int gap;
        gap = tx_calm ? 0 : gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_gate_sample <= g;
        i_last_in_row <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
        if (last) rows_sent++;
    endtask

    task automatic send_row(input int len);
        for (int i = 0; i < len; i++) send_item(pick_sample(), i == len - 1);
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_weights != 0) @(posedge i_clk);
    endtask

    task automatic hold_then_settle();
        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // receiver: stall bursts of random length
    initial begin
        int n;
        i_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = rx_calm ? 0 : gap_len();
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet <= 0;
        else quiet <= quiet + 1;
    end

    initial begin
        while (quiet < QUIET_LIMIT) @(posedge i_clk);
        $display("tb_gate_weight_map_core: errors");
        $finish;
    end

    initial begin
        int k;
        int target;
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_gate_sample <= '0;
        i_last_in_row <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cur           = '0;
        cur.slope     = ONE_Q12;
        cur.cap_level = ONE_Q12;
        cur.use_min   = 1'b1;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_item(Q_MAX, 1'b1);
        send_item(Q_MIN, 1'b1);
        send_item('0, 1'b1);
        send_item(16'sd4096, 1'b0);
        send_item(-16'sd4096, 1'b1);
        send_item(16'sd1000, 1'b0);
        send_item(-16'sd2000, 1'b0);
        send_item(16'sd3000, 1'b0);
        send_item(16'sd500, 1'b0);
        send_item(Q_MIN, 1'b0);
        send_item(Q_MAX, 1'b0);
        send_item('0, 1'b1);
        send_item(Q_MAX, 1'b0);
        send_item(Q_MIN, 1'b0);
        send_item(Q_MAX, 1'b1);
        hold_then_settle();

        for (k = 0; k < 4; k++) begin
            load_config(corner_cfg(k));
            send_item(Q_MIN, 1'b0);
            send_item('0, 1'b0);
            send_item(Q_MAX, 1'b0);
            send_item(16'sd12, 1'b1);
            send_item(Q_MAX, 1'b1);
            repeat (3) send_row(row_len());
            hold_then_settle();
        end

        reg_write(REG_UNUSED_A, $urandom);
        reg_write(REG_UNUSED_B, $urandom);

        k = 0;
        while (items_sent < ROW_ITEMS) begin
            load_config(random_cfg());
            tx_calm = (k % 4 == 1);
            rx_calm = (k % 4 == 1) || (k % 4 == 3);
            target  = items_sent + $urandom_range(50, 90);
            if (k == 2) begin
                repeat (3) send_item(pick_sample(), 1'b0);
                hold_until_drained();
                repeat (2) send_item(pick_sample(), 1'b0);
                send_item(pick_sample(), 1'b1);
            end
            while (items_sent < target) send_row(row_len());
            hold_then_settle();
            k++;
        end

        $display("covered %0d items in %0d rows, %0d weights checked",
                 items_sent, rows_sent, weights_checked);
        $display("%0d register writes over %0d register settings", reg_writes, configs_loaded);
        if (fail_count == 0) begin
            $display("tb_gate_weight_map_core: clean");
        end else begin
            $display("tb_gate_weight_map_core: errors");
        end
        $finish;
    end

endmodule

// ----- gate_weight_map_core.f -----
+incdir+design
design/gwm_pkg.sv
design/gwm_map.sv
design/gate_weight_map_core.sv
design/gwm_checker.sv
tb/sv/gate_weight_monitor.sv
tb/sv/tb_gate_weight_map_core.sv
